// File: src/sttp_pkg.sv
// sttp_pkg: shared types, character constants and lookup functions
// for the stream target path parser; no dependencies
package sttp_pkg;

  localparam int INDEX_BITS_DEF = 32;
  localparam int STREAM_INDEX_W = 32;

  localparam logic [3:0] MARK_LEN = 4'd9;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] KIND_VIDEO   = 2'd0;
  localparam logic [1:0] KIND_AUDIO   = 2'd1;
  localparam logic [1:0] KIND_CONTROL = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [2:0] KIND_ALL = 3'b111;

  typedef enum logic [1:0] {
    PH_KIND,
    PH_INDEX,
    PH_TAIL,
    PH_REJECT
  } phase_t;

  typedef struct packed {
    logic completed;
    logic found;
    logic lead_ok;
  } marker_stat_t;

  typedef struct packed {
    logic                      ok;
    logic [1:0]                kind;
    logic [STREAM_INDEX_W-1:0] index;
  } verdict_t;

  // "streamid=" by position
  function automatic logic [7:0] mark_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h73;
      4'd1:    ch = 8'h74;
      4'd2:    ch = 8'h72;
      4'd3:    ch = 8'h65;
      4'd4:    ch = 8'h61;
      4'd5:    ch = 8'h6d;
      4'd6:    ch = 8'h69;
      4'd7:    ch = 8'h64;
      4'd8:    ch = 8'h3d;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] kind_len(input logic [1:0] kind);
    logic [2:0] len;
    case (kind)
      KIND_VIDEO:   len = 3'd5;
      KIND_AUDIO:   len = 3'd5;
      KIND_CONTROL: len = 3'd7;
      default:      len = 3'd0;
    endcase
    return len;
  endfunction

  // "video", "audio", "control" by position
  function automatic logic [7:0] kind_char(input logic [1:0] kind, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (kind)
      KIND_VIDEO: begin
        case (pos)
          3'd0:    ch = 8'h76;
          3'd1:    ch = 8'h69;
          3'd2:    ch = 8'h64;
          3'd3:    ch = 8'h65;
          3'd4:    ch = 8'h6f;
          default: ch = 8'h00;
        endcase
      end
      KIND_AUDIO: begin
        case (pos)
          3'd0:    ch = 8'h61;
          3'd1:    ch = 8'h75;
          3'd2:    ch = 8'h64;
          3'd3:    ch = 8'h69;
          3'd4:    ch = 8'h6f;
          default: ch = 8'h00;
        endcase
      end
      KIND_CONTROL: begin
        case (pos)
          3'd0:    ch = 8'h63;
          3'd1:    ch = 8'h6f;
          3'd2:    ch = 8'h6e;
          3'd3:    ch = 8'h74;
          3'd4:    ch = 8'h72;
          3'd5:    ch = 8'h6f;
          3'd6:    ch = 8'h6c;
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: src/sttp_marker.sv
// sttp_marker: search for the first "streamid=" marker and its lead
// depends on sttp_pkg
module sttp_marker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [7:0]                char_code,
  input  logic                      last_char,
  output sttp_pkg::marker_stat_t    stat
);

  logic [3:0] progress;
  logic       found;
  logic       lead_ok;
  logic       prior_slash;

  logic [3:0] progress_next;
  logic       found_next;
  logic       lead_ok_next;
  logic       completed;

  always_comb begin
    progress_next = progress;
    found_next    = found;
    lead_ok_next  = lead_ok;
    completed     = 1'b0;
    if (!found) begin
      if (progress < sttp_pkg::MARK_LEN && sttp_pkg::mark_char(progress) == char_code) begin
        if (progress == 4'd0) begin
          lead_ok_next = prior_slash;
        end
        progress_next = progress + 4'd1;
      end else if (char_code == sttp_pkg::mark_char(4'd0)) begin
        lead_ok_next  = prior_slash;
        progress_next = 4'd1;
      end else begin
        progress_next = 4'd0;
      end
      if (progress_next == sttp_pkg::MARK_LEN) begin
        found_next = 1'b1;
        completed  = 1'b1;
      end
    end
  end

  assign stat.completed = completed;
  assign stat.found     = found_next;
  assign stat.lead_ok   = lead_ok_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      progress    <= 4'd0;
      found       <= 1'b0;
      lead_ok     <= 1'b0;
      prior_slash <= 1'b1;
    end else if (en) begin
      if (last_char) begin
        progress    <= 4'd0;
        found       <= 1'b0;
        lead_ok     <= 1'b0;
        prior_slash <= 1'b1;
      end else begin
        progress    <= progress_next;
        found       <= found_next;
        lead_ok     <= lead_ok_next;
        prior_slash <= (char_code == sttp_pkg::CH_SLASH);
      end
    end
  end

endmodule

// File: src/sttp_parser.sv
// sttp_parser: kind word, index and tail parser with verdict logic
// depends on sttp_pkg; takes marker status from sttp_marker
module sttp_parser #(
  parameter int INDEX_BITS = sttp_pkg::INDEX_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [7:0]                char_code,
  input  logic                      last_char,
  input  sttp_pkg::marker_stat_t    mstat,
  output sttp_pkg::verdict_t        verdict
);

  localparam int WIDE_W = INDEX_BITS + 4;

  sttp_pkg::phase_t      phase;
  logic [2:0]            word_pos;
  logic [2:0]            cands;
  logic [INDEX_BITS-1:0] index_value;
  logic                  has_digit;
  logic                  leading_zero;
  logic                  tail_seen;
  logic                  stopped;

  sttp_pkg::phase_t      phase_next;
  logic [2:0]            word_pos_next;
  logic [2:0]            cands_next;
  logic [INDEX_BITS-1:0] index_value_next;
  logic                  has_digit_next;
  logic                  leading_zero_next;
  logic                  tail_seen_next;
  logic                  stopped_next;

  logic [WIDE_W-1:0]     index_wide;
  logic                  is_digit;

  // lowest kind whose word ends at the position, or none
  function automatic logic [1:0] complete_kind(input logic [2:0] cs, input logic [2:0] pos);
    logic [1:0] k;
    k = sttp_pkg::KIND_NONE;
    if (cs[2] && pos == sttp_pkg::kind_len(sttp_pkg::KIND_CONTROL)) begin
      k = sttp_pkg::KIND_CONTROL;
    end
    if (cs[1] && pos == sttp_pkg::kind_len(sttp_pkg::KIND_AUDIO)) begin
      k = sttp_pkg::KIND_AUDIO;
    end
    if (cs[0] && pos == sttp_pkg::kind_len(sttp_pkg::KIND_VIDEO)) begin
      k = sttp_pkg::KIND_VIDEO;
    end
    return k;
  endfunction

  assign is_digit   = (char_code >= sttp_pkg::CH_ZERO) && (char_code <= sttp_pkg::CH_NINE);
  assign index_wide = ({4'd0, index_value} << 3) + ({4'd0, index_value} << 1)
                    + WIDE_W'(char_code[3:0]);

  always_comb begin
    logic [1:0] k;
    k                 = complete_kind(cands, word_pos);
    phase_next        = phase;
    word_pos_next     = word_pos;
    cands_next        = cands;
    index_value_next  = index_value;
    has_digit_next    = has_digit;
    leading_zero_next = leading_zero;
    tail_seen_next    = tail_seen;
    stopped_next      = stopped;
    if (mstat.completed) begin
      phase_next        = sttp_pkg::PH_KIND;
      word_pos_next     = 3'd0;
      cands_next        = sttp_pkg::KIND_ALL;
      index_value_next  = '0;
      has_digit_next    = 1'b0;
      leading_zero_next = 1'b0;
      tail_seen_next    = 1'b0;
      stopped_next      = 1'b0;
    end else if (!stopped && phase != sttp_pkg::PH_REJECT) begin
      if (char_code == sttp_pkg::CH_QUEST || char_code == sttp_pkg::CH_SPACE) begin
        stopped_next = 1'b1;
      end else begin
        case (phase)
          sttp_pkg::PH_KIND: begin
            if (char_code == sttp_pkg::CH_SLASH) begin
              if (k == sttp_pkg::KIND_NONE) begin
                phase_next = sttp_pkg::PH_REJECT;
              end else begin
                cands_next = 3'b001 << k;
                phase_next = sttp_pkg::PH_INDEX;
              end
            end else begin
              for (int i = 0; i < 3; i++) begin
                if (word_pos >= sttp_pkg::kind_len(2'(i)) ||
                    sttp_pkg::kind_char(2'(i), word_pos) != char_code) begin
                  cands_next[i] = 1'b0;
                end
              end
              if (word_pos != 3'd7) begin
                word_pos_next = word_pos + 3'd1;
              end
            end
          end
          sttp_pkg::PH_INDEX: begin
            if (char_code == sttp_pkg::CH_SLASH) begin
              phase_next = has_digit ? sttp_pkg::PH_TAIL : sttp_pkg::PH_REJECT;
            end else if (!is_digit || (has_digit && leading_zero)) begin
              phase_next = sttp_pkg::PH_REJECT;
            end else if (index_wide[WIDE_W-1:INDEX_BITS] != 4'd0) begin
              phase_next = sttp_pkg::PH_REJECT;
            end else begin
              if (!has_digit && char_code == sttp_pkg::CH_ZERO) begin
                leading_zero_next = 1'b1;
              end
              index_value_next = index_wide[INDEX_BITS-1:0];
              has_digit_next   = 1'b1;
            end
          end
          sttp_pkg::PH_TAIL: begin
            if (!tail_seen && char_code == sttp_pkg::CH_ZERO) begin
              tail_seen_next = 1'b1;
            end else begin
              phase_next = sttp_pkg::PH_REJECT;
            end
          end
          default: begin
            phase_next = sttp_pkg::PH_REJECT;
          end
        endcase
      end
    end
  end

  always_comb begin
    logic [1:0] kf;
    logic [1:0] kt;
    logic       ok;
    logic [1:0] kind;
    logic [sttp_pkg::STREAM_INDEX_W-1:0] idx;
    kf   = complete_kind(cands_next, word_pos_next);
    kt   = cands_next[0] ? sttp_pkg::KIND_VIDEO :
           (cands_next[1] ? sttp_pkg::KIND_AUDIO : sttp_pkg::KIND_CONTROL);
    ok   = 1'b0;
    kind = sttp_pkg::KIND_VIDEO;
    idx  = '0;
    if (!(mstat.found && !mstat.lead_ok)) begin
      if (phase_next == sttp_pkg::PH_KIND) begin
        if (kf != sttp_pkg::KIND_NONE) begin
          ok   = 1'b1;
          kind = kf;
        end
      end else if (phase_next == sttp_pkg::PH_TAIL && tail_seen_next) begin
        kind = kt;
        idx  = sttp_pkg::STREAM_INDEX_W'(index_value_next);
        ok   = !(kt == sttp_pkg::KIND_VIDEO && index_value_next > INDEX_BITS'(1));
      end
    end
    verdict.ok    = ok;
    verdict.kind  = ok ? kind : sttp_pkg::KIND_VIDEO;
    verdict.index = ok ? idx : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= sttp_pkg::PH_KIND;
      word_pos     <= 3'd0;
      cands        <= sttp_pkg::KIND_ALL;
      index_value  <= '0;
      has_digit    <= 1'b0;
      leading_zero <= 1'b0;
      tail_seen    <= 1'b0;
      stopped      <= 1'b0;
    end else if (en) begin
      if (last_char) begin
        phase        <= sttp_pkg::PH_KIND;
        word_pos     <= 3'd0;
        cands        <= sttp_pkg::KIND_ALL;
        index_value  <= '0;
        has_digit    <= 1'b0;
        leading_zero <= 1'b0;
        tail_seen    <= 1'b0;
        stopped      <= 1'b0;
      end else begin
        phase        <= phase_next;
        word_pos     <= word_pos_next;
        cands        <= cands_next;
        index_value  <= index_value_next;
        has_digit    <= has_digit_next;
        leading_zero <= leading_zero_next;
        tail_seen    <= tail_seen_next;
        stopped      <= stopped_next;
      end
    end
  end

  a_reset_after_last: assert property (@(posedge clk) disable iff (rst)
    $past(en && last_char) |-> (phase == sttp_pkg::PH_KIND && cands == sttp_pkg::KIND_ALL
                                && !stopped && index_value == '0))
    else $error("parser state not cleared after last word");

  a_single_kind_past_word: assert property (@(posedge clk) disable iff (rst)
    (phase == sttp_pkg::PH_INDEX || phase == sttp_pkg::PH_TAIL) |-> $onehot(cands))
    else $error("more than one kind left after the kind word");

  a_tail_needs_digit: assert property (@(posedge clk) disable iff (rst)
    (phase == sttp_pkg::PH_TAIL) |-> has_digit)
    else $error("tail reached without an index digit");

endmodule

// File: src/stream_target_path_parser.sv
// stream_target_path_parser: top level with input and result registers
// depends on sttp_pkg, sttp_marker, sttp_parser
//
// usage:
//   slave channel s_*: one character of the target text per word,
//   s_tlast set on the final character of a target.
//   master channel m_*: one verdict word per target, sent after the
//   word that carried s_tlast.
// datapath: a character word is registered at the input and parsed from
//   the input register; for the last character the verdict is then loaded
//   into the result register, which drives m_tvalid.
// throughput: one character per cycle while no final character waits on a
//   pending verdict; marker and parser state update as each one is parsed.
// reset: rst clears the input and result valid flags and all parse state;
//   the next character starts a new target.
// stall: while a verdict waits on m_tready the next target's characters
//   keep flowing; a second final character waits in the input register
//   with s_tready low until the pending verdict is taken.
module stream_target_path_parser #(
  parameter int INDEX_BITS = sttp_pkg::INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [0] target_valid, [2:1] stream_kind, [34:3] stream_index
);

  logic                   in_valid;
  logic [7:0]             in_char;
  logic                   in_last;
  logic                   proc;
  logic                   load;

  logic                   out_valid;
  sttp_pkg::verdict_t     out_verdict;

  sttp_pkg::marker_stat_t mstat;
  sttp_pkg::verdict_t     verdict;

  assign proc     = in_valid && (!in_last || !out_valid || m_tready);
  assign load     = proc && in_last;
  assign s_tready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (proc) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  sttp_marker u_marker (
    .clk       (clk),
    .rst       (rst),
    .en        (proc),
    .char_code (in_char),
    .last_char (in_last),
    .stat      (mstat)
  );

  sttp_parser #(
    .INDEX_BITS (INDEX_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .en        (proc),
    .char_code (in_char),
    .last_char (in_last),
    .mstat     (mstat),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_verdict <= verdict;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_verdict.index, out_verdict.kind, out_verdict.ok};

  a_rise_needs_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(load))
    else $error("verdict raised without a final character");

  a_reject_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_verdict.ok) |-> (out_verdict.kind == sttp_pkg::KIND_VIDEO
                                       && out_verdict.index == '0))
    else $error("rejected verdict carries a kind or index");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !load)
    else $error("pending verdict overwritten");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_verdict.kind != sttp_pkg::KIND_NONE)
    else $error("illegal stream kind");

endmodule

// File: tb/target_verdict_checker.sv
`timescale 1ns / 100ps
// target_verdict_checker: watches both channels of stream_target_path_parser,
// predicts the verdict of each target from its characters and compares it
// depends on sttp_pkg
module target_verdict_checker #(
  parameter int INDEX_BITS = sttp_pkg::INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // last_char
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // [0] target_valid, [2:1] stream_kind, [34:3] stream_index
  output int          fail_count,
  output int          pending,
  output int          checked,
  output int          accepted
);

  localparam logic [71:0] MARKER_TEXT = "streamid=";
  localparam logic [63:0] INDEX_MAX = (64'd1 << INDEX_BITS) - 64'd1;

  // marker search state
  logic [3:0] mk_pos;
  logic       mk_done;
  logic       mk_lead;
  logic       after_slash;
  // target parse state
  sttp_pkg::phase_t phase;
  logic [2:0] word_pos;
  logic [2:0] cands;
  logic [sttp_pkg::STREAM_INDEX_W-1:0] idx;
  logic [1:0] ndig;
  logic       lead_zero;
  logic       tail_zero;
  logic       stopped;

  sttp_pkg::verdict_t verdicts_due[$];
  int mism = 0;
  int n_checked = 0;
  int n_accepted = 0;

  function automatic logic [7:0] marker_byte(input logic [3:0] p);
    return MARKER_TEXT[8*(8 - int'(p)) +: 8];
  endfunction

  function automatic logic [2:0] word_len(input logic [1:0] k);
    return (k == sttp_pkg::KIND_CONTROL) ? 3'd7 : 3'd5;
  endfunction

  function automatic logic [7:0] word_byte(input logic [1:0] k, input logic [2:0] p);
    logic [55:0] w;
    case (k)
      sttp_pkg::KIND_VIDEO: w = "video";
      sttp_pkg::KIND_AUDIO: w = "audio";
      default:              w = "control";
    endcase
    return w[8*(int'(word_len(k)) - 1 - int'(p)) +: 8];
  endfunction

  // first kind whose word ends exactly here
  function automatic logic [1:0] finished_kind();
    for (int k = 0; k < 3; k++) begin
      if (cands[k] && word_pos == word_len(k[1:0])) return k[1:0];
    end
    return sttp_pkg::KIND_NONE;
  endfunction

  task automatic clear_parse();
    phase = sttp_pkg::PH_KIND;
    word_pos = 3'd0;
    cands = sttp_pkg::KIND_ALL;
    idx = '0;
    ndig = 2'd0;
    lead_zero = 1'b0;
    tail_zero = 1'b0;
    stopped = 1'b0;
  endtask

  task automatic clear_all();
    mk_pos = 4'd0;
    mk_done = 1'b0;
    mk_lead = 1'b0;
    after_slash = 1'b1;
    clear_parse();
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic [1:0]  k;
    logic [63:0] grown;
    if (stopped || phase == sttp_pkg::PH_REJECT) return;
    if (c == sttp_pkg::CH_QUEST || c == sttp_pkg::CH_SPACE) begin
      stopped = 1'b1;
      return;
    end
    case (phase)
      sttp_pkg::PH_KIND: begin
        if (c == sttp_pkg::CH_SLASH) begin
          k = finished_kind();
          if (k == sttp_pkg::KIND_NONE) begin
            phase = sttp_pkg::PH_REJECT;
          end else begin
            cands = 3'b001 << k;
            phase = sttp_pkg::PH_INDEX;
          end
        end else begin
          for (int j = 0; j < 3; j++) begin
            if (word_pos >= word_len(j[1:0]) || word_byte(j[1:0], word_pos) != c)
              cands[j] = 1'b0;
          end
          if (word_pos < 3'd7) word_pos = word_pos + 3'd1;
        end
      end
      sttp_pkg::PH_INDEX: begin
        if (c == sttp_pkg::CH_SLASH) begin
          phase = (ndig == 2'd0) ? sttp_pkg::PH_REJECT : sttp_pkg::PH_TAIL;
        end else if (c < sttp_pkg::CH_ZERO || c > sttp_pkg::CH_NINE ||
                     (ndig != 2'd0 && lead_zero)) begin
          phase = sttp_pkg::PH_REJECT;
        end else begin
          grown = {32'd0, idx} * 64'd10 + {56'd0, c - sttp_pkg::CH_ZERO};
          if (grown > INDEX_MAX) begin
            phase = sttp_pkg::PH_REJECT;
          end else begin
            if (ndig == 2'd0 && c == sttp_pkg::CH_ZERO) lead_zero = 1'b1;
            idx = grown[sttp_pkg::STREAM_INDEX_W-1:0];
            if (ndig < 2'd3) ndig = ndig + 2'd1;
          end
        end
      end
      default: begin
        if (!tail_zero && c == sttp_pkg::CH_ZERO) tail_zero = 1'b1;
        else phase = sttp_pkg::PH_REJECT;
      end
    endcase
  endtask

  task automatic take_char(input logic [7:0] c, input logic last);
    logic     restarted;
    logic [1:0] k;
    sttp_pkg::verdict_t v;
    restarted = 1'b0;
    if (!mk_done) begin
      if (mk_pos < sttp_pkg::MARK_LEN && marker_byte(mk_pos) == c) begin
        if (mk_pos == 4'd0) mk_lead = after_slash;
        mk_pos = mk_pos + 4'd1;
      end else if (c == marker_byte(4'd0)) begin
        mk_lead = after_slash;
        mk_pos = 4'd1;
      end else begin
        mk_pos = 4'd0;
      end
      if (mk_pos >= sttp_pkg::MARK_LEN) begin
        mk_done = 1'b1;
        restarted = 1'b1;
        clear_parse();
      end
    end
    after_slash = (c == sttp_pkg::CH_SLASH);
    if (!restarted) parse_char(c);
    if (!last) return;

    v.ok = 1'b0;
    v.kind = sttp_pkg::KIND_VIDEO;
    v.index = '0;
    if (!(mk_done && !mk_lead)) begin
      if (phase == sttp_pkg::PH_KIND) begin
        k = finished_kind();
        if (k != sttp_pkg::KIND_NONE) begin
          v.ok = 1'b1;
          v.kind = k;
        end
      end else if (phase == sttp_pkg::PH_TAIL && tail_zero) begin
        v.kind = cands[0] ? sttp_pkg::KIND_VIDEO :
                 (cands[1] ? sttp_pkg::KIND_AUDIO : sttp_pkg::KIND_CONTROL);
        v.index = idx;
        v.ok = !(v.kind == sttp_pkg::KIND_VIDEO && idx > 1);
      end
    end
    if (!v.ok) begin
      v.kind = sttp_pkg::KIND_VIDEO;
      v.index = '0;
    end
    verdicts_due.push_back(v);
    clear_all();
  endtask

  task automatic check_verdict(input logic [39:0] word);
    sttp_pkg::verdict_t want;
    if (verdicts_due.size() == 0) begin
      mism++;
      if (mism <= 10) $display("%0t: verdict word %h arrived with none expected", $time, word);
      return;
    end
    want = verdicts_due.pop_front();
    n_checked++;
    if (word[0]) n_accepted++;
    if (word[0] !== want.ok || word[2:1] !== want.kind || word[34:3] !== want.index ||
        word[39:35] !== 5'd0) begin
      mism++;
      if (mism <= 10)
        $display("%0t: expected ok %0d kind %0d index %0d, got %0d %0d %0d pad %h",
                 $time, want.ok, want.kind, want.index, word[0], word[2:1], word[34:3],
                 word[39:35]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_all();
      verdicts_due.delete();
    end else begin
      if (s_tvalid && s_tready) take_char(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_verdict(m_tdata);
    end
    fail_count <= mism;
    pending <= verdicts_due.size();
    checked <= n_checked;
    accepted <= n_accepted;
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// testbench: feeds target text into stream_target_path_parser with random gaps,
// output back-pressure and one long output hold; target_verdict_checker judges
// depends on sttp_pkg, stream_target_path_parser and target_verdict_checker
module testbench;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_CHARS = 310;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  int fail_count;
  int pending;
  int checked;
  int accepted;

  logic quiet = 1'b0;
  logic want_hold = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   cycles = 0;
  int   chars_sent = 0;
  int   targets_sent = 0;
  int   rand_chars = 0;
  logic [7:0] text[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stream_target_path_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  target_verdict_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .accepted   (accepted)
  );

  // verdict side: random stalls, one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (want_hold && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] c, input logic last);
    if (!quiet) begin
      while ($urandom_range(99) < 33) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text.size(); i++) send_word(text[i], i == text.size() - 1);
    targets_sent++;
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endtask

  task automatic run_text(input string s);
    text.delete();
    put_str(s);
    send_text();
  endtask

  function automatic string kind_name(input logic [1:0] k);
    case (k)
      sttp_pkg::KIND_VIDEO: return "video";
      sttp_pkg::KIND_AUDIO: return "audio";
      default:              return "control";
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    string s;
    s = "streamid=/?0 1vx";
    return s[$urandom_range(s.len() - 1)];
  endfunction

  task automatic put_letters();
    int n;
    n = $urandom_range(1, 5);
    repeat (n) text.push_back(8'(8'h61 + $urandom_range(25)));
  endtask

  task automatic put_index(input logic [1:0] k);
    logic [63:0] v;
    case ($urandom_range(9))
      0, 1, 2: v = (k == sttp_pkg::KIND_VIDEO) ? 64'($urandom_range(2))
                                               : 64'($urandom_range(9));
      3:       v = 64'($urandom_range(10, 9999));
      4:       v = 64'($urandom);
      5:       v = 64'hFFFF_FFFF - 64'($urandom_range(5));
      6:       v = 64'h1_0000_0000 + 64'($urandom_range(1000));
      7:       v = {$urandom, $urandom};
      8: begin
        put_str("0");
        v = 64'($urandom_range(99));
      end
      default: v = 64'd0;
    endcase
    put_str($sformatf("%0d", v));
  endtask

  task automatic put_well_formed();
    int p;
    int n;
    logic [1:0] k;
    p = $urandom_range(9);
    if (p < 2) begin
      put_str("streamid=");
    end else if (p < 4) begin
      put_str("rtsp://");
      put_letters();
      put_str("/streamid=");
    end else if (p == 4) begin
      put_letters();
      put_str("streamid=");
    end
    k = 2'($urandom_range(2));
    put_str(kind_name(k));
    if ($urandom_range(2) != 0) begin
      put_str("/");
      put_index(k);
      put_str("/0");
    end
    p = $urandom_range(9);
    if (p < 2) begin
      put_str(p == 0 ? "?" : " ");
      n = $urandom_range(6);
      repeat (n) text.push_back(8'($urandom_range(255)));
      if ($urandom_range(3) == 0) put_str("/streamid=audio");
    end
  endtask

  task automatic put_random_target();
    int form;
    int n;
    int pos;
    text.delete();
    form = $urandom_range(99);
    if (form < 60) begin
      put_well_formed();
    end else if (form < 85) begin
      put_well_formed();
      pos = $urandom_range(text.size() - 1);
      case ($urandom_range(2))
        0:       text[pos] = 8'($urandom_range(255));
        1:       text[pos] = pick_char();
        default: while (text.size() > pos + 1) text.delete(text.size() - 1);
      endcase
    end else begin
      n = $urandom_range(1, 12);
      repeat (n) text.push_back($urandom_range(1) ? 8'($urandom_range(255)) : pick_char());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    run_text("video");
    run_text("audio");
    run_text("control");
    run_text("video/1/0");
    run_text("video/2/0");
    run_text("audio/4294967295/0");
    run_text("audio/4294967296/0");
    run_text("control/0/0");
    run_text("control/01/0");
    run_text("audio//0");
    run_text("audio/5/0x");
    run_text("audio/5/0/");
    run_text("streamid=video/0/0");
    run_text("rtsp://h/streamid=audio/7/0");
    run_text("xstreamid=audio");
    run_text("streamid=");
    run_text("/sstreamid=video");
    run_text("streamid=audio streamid=video");
    run_text("audio?/streamid=video/1/0");
    run_text("audio?x/y");
    run_text("control 9");
    run_text("vide\357");
    run_text("videos");
    text.delete();
    text.push_back(8'h00);
    send_text();
    text.delete();
    text.push_back(8'hff);
    send_text();

    // hold the verdict side so the block backs up
    want_hold <= 1'b1;
    repeat (30) run_text("video");

    while (rand_chars < RANDOM_CHARS) begin
      quiet = (rand_chars >= 100 && rand_chars < 250);
      put_random_target();
      send_text();
      rand_chars += text.size();
    end
    quiet = 1'b0;
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d characters in %0d targets, %0d verdicts compared, %0d accepted",
             chars_sent, targets_sent, checked, accepted);
    $display("with random gaps on both sides and a %0d-cycle verdict hold", HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d verdicts outstanding", fail_count, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
